/* rtl/cor_pkg.sv */
// Shared constants for the circle octant rasterizer.
// No dependencies; every other file in rtl/ imports this package.
package cor_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int COLOR_BITS      = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PIXELS_PER_STEP = 8;
    localparam int PIX_IDX_BITS    = $clog2(PIXELS_PER_STEP);

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Midpoint decision constants.
    localparam int DEC_INIT   = 3;
    localparam int DEC_INC_X  = 6;
    localparam int DEC_INC_XY = 10;

endpackage

/* rtl/cor_front.sv */
// Front end: takes requests, keeps the circle state and the midpoint decision,
// and queues one descriptor per step. Depends on cor_pkg.
module cor_front #(
    parameter int COORD_BITS = cor_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 2 + cor_pkg::COLOR_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_mode,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [COORD_BITS-1:0]         i_radius,
    input  logic [cor_pkg::COLOR_BITS-1:0] i_color,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [ENTRY_W-1:0]            o_q_data
);
    import cor_pkg::*;

    localparam int OFF_W = COORD_BITS + 1;
    localparam int DEC_W = COORD_BITS + 6;

    logic                  r_active;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COLOR_BITS-1:0] r_color;
    logic [OFF_W-1:0]      r_a;
    logic [OFF_W-1:0]      r_b;
    logic [DEC_W-1:0]      r_dec;

    logic             accept;
    logic             do_step;
    logic [DEC_W-1:0] a_dec;
    logic [DEC_W-1:0] b_dec;
    logic [DEC_W-1:0] r_ext;
    logic [DEC_W-1:0] n_dec_step;
    logic [DEC_W-1:0] n_dec_start;
    logic [OFF_W-1:0] n_a_step;
    logic [OFF_W-1:0] n_b_step;
    logic             step_done;

    assign accept  = i_push && !i_q_full;
    assign do_step = accept && (i_mode == MODE_STEP) && r_active;

    assign a_dec = {{(DEC_W-OFF_W){r_a[OFF_W-1]}}, r_a};
    assign b_dec = {{(DEC_W-OFF_W){r_b[OFF_W-1]}}, r_b};
    assign r_ext = {{(DEC_W-COORD_BITS){1'b0}}, i_radius};

    always_comb begin
        if (r_dec[DEC_W-1]) begin
            n_dec_step = r_dec + (a_dec << 2) + DEC_W'(DEC_INC_X);
            n_b_step   = r_b;
        end else begin
            n_dec_step = r_dec + ((a_dec - b_dec) << 2) + DEC_W'(DEC_INC_XY);
            n_b_step   = r_b - OFF_W'(1);
        end
        n_a_step    = r_a + OFF_W'(1);
        n_dec_start = DEC_W'(DEC_INIT) - (r_ext << 1);
    end

    assign step_done = $signed(n_a_step) > $signed(n_b_step);

    // Descriptor carries the pre-update offsets.
    assign o_q_push = do_step;
    assign o_q_data = {r_cx, r_cy, r_a, r_b, r_color, step_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_dec    <= '0;
        end else if (accept && (i_mode == MODE_START)) begin
            r_active <= 1'b1;
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_color  <= i_color;
            r_a      <= '0;
            r_b      <= {1'b0, i_radius};
            r_dec    <= n_dec_start;
        end else if (do_step) begin
            r_active <= !step_done;
            r_a      <= n_a_step;
            r_b      <= n_b_step;
            r_dec    <= n_dec_step;
        end
    end

endmodule

/* rtl/cor_queue.sv */
// Short register queue between the front end and the pixel emitter.
// Depends on cor_pkg.
module cor_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cor_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import cor_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree while empty");
`endif

endmodule

/* rtl/cor_back.sv */
// Back end: expands one step descriptor into eight symmetric pixels, one
// per cycle into an output register unless it holds an unpopped pixel. Depends on cor_pkg.
module cor_back #(
    parameter int COORD_BITS = cor_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 2 + cor_pkg::COLOR_BITS + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [ENTRY_W-1:0]             i_q_data,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [COORD_BITS+1:0]          o_pixel_x,
    output logic [COORD_BITS+1:0]          o_pixel_y,
    output logic [cor_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_of_step,
    output logic                           o_circle_done
);
    import cor_pkg::*;

    localparam int OFF_W = COORD_BITS + 1;
    localparam int PIX_W = COORD_BITS + 2;
    localparam logic [PIX_IDX_BITS-1:0] K_LAST = PIX_IDX_BITS'(PIXELS_PER_STEP - 1);

    logic                    r_busy;
    logic [PIX_IDX_BITS-1:0] r_k;
    logic [COORD_BITS-1:0]   r_cx;
    logic [COORD_BITS-1:0]   r_cy;
    logic [OFF_W-1:0]        r_a;
    logic [OFF_W-1:0]        r_b;
    logic [COLOR_BITS-1:0]   r_color;
    logic                    r_done;

    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_px;
    logic [PIX_W-1:0]      r_py;
    logic [COLOR_BITS-1:0] r_pcol;
    logic                  r_plast;
    logic                  r_pdone;

    logic             load_out;
    logic             step_end;
    logic             take;
    logic [PIX_W-1:0] cx_ext;
    logic [PIX_W-1:0] cy_ext;
    logic [PIX_W-1:0] a_ext;
    logic [PIX_W-1:0] b_ext;
    logic [PIX_W-1:0] sel_x;
    logic [PIX_W-1:0] sel_y;
    logic [PIX_W-1:0] n_px;
    logic [PIX_W-1:0] n_py;

    assign load_out = r_busy && (!r_out_valid || i_pop);
    assign step_end = load_out && (r_k == K_LAST);
    assign take     = i_q_valid && (!r_busy || step_end);
    assign o_q_pop  = take;

    assign cx_ext = {2'b00, r_cx};
    assign cy_ext = {2'b00, r_cy};
    assign a_ext  = {r_a[OFF_W-1], r_a};
    assign b_ext  = {r_b[OFF_W-1], r_b};

    // Index bit 0 swaps the offsets, bit 1 mirrors x, bit 2 mirrors y.
    always_comb begin
        sel_x = r_k[0] ? b_ext : a_ext;
        sel_y = r_k[0] ? a_ext : b_ext;
        n_px  = r_k[1] ? (cx_ext - sel_x) : (cx_ext + sel_x);
        n_py  = r_k[2] ? (cy_ext + sel_y) : (cy_ext - sel_y);
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            {r_cx, r_cy, r_a, r_b, r_color, r_done} <= i_q_data;
        end
        if (load_out) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pcol  <= r_color;
            r_plast <= (r_k == K_LAST);
            r_pdone <= (r_k == K_LAST) && r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (step_end) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_k <= (r_k == K_LAST) ? '0 : r_k + PIX_IDX_BITS'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_color  = r_pcol;
    assign o_last_of_step = r_plast;
    assign o_circle_done  = r_pdone;

`ifndef SYNTHESIS
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_k == '0))
        else $error("pixel index not parked while idle");
    a_wrap_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_end |=> (r_k == '0))
        else $error("pixel index did not wrap after the eighth pixel");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pdone) |-> r_plast)
        else $error("circle done outside the last pixel of a step");
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!r_busy || (r_k == K_LAST)))
        else $error("descriptor taken mid-step");
`endif

endmodule

/* rtl/circle_octant_rasterizer.sv */
// Circle octant rasterizer (midpoint scheme): start request latches a circle, step
// request yields eight pixels. A step's descriptor passes through the queue and the back
// end's descriptor registers to the output register. Start requests one per cycle while
// the queue has room; step requests queue while it has room, and the back end writes one
// pixel per cycle into the single output register while it is empty or being popped.
// Reset: synchronous, active low; clears the circle to idle and empties queue and output.
module circle_octant_rasterizer #(
    parameter int COORD_BITS = cor_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_mode,
    input  logic [COORD_BITS-1:0]          i_center_x,
    input  logic [COORD_BITS-1:0]          i_center_y,
    input  logic [COORD_BITS-1:0]          i_radius,
    input  logic [cor_pkg::COLOR_BITS-1:0] i_color,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [COORD_BITS+1:0]          o_pixel_x,
    output logic [COORD_BITS+1:0]          o_pixel_y,
    output logic [cor_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_of_step,
    output logic                           o_circle_done
);
    import cor_pkg::*;

    localparam int ENTRY_W = 4 * COORD_BITS + 2 + COLOR_BITS + 1;

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    assign o_full = q_full;

    cor_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_mode     (i_mode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    cor_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    cor_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule
